// File: rtl/tws_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Three-wire bus sniffer package
// Widths, register indexes and shared types for the byte sniffer.
// ----------------------------------------------------------------------------
package tws_pkg;

  localparam int RUN_W   = 24;
  localparam int THR_W   = 24;
  localparam int BYTE_W  = 8;
  localparam int BITCNT_W = 4;
  localparam int CMP_W   = (RUN_W > THR_W) ? RUN_W : THR_W;
  localparam int CFG_W   = 24;
  localparam int CFG_IDX_W = 1;

  localparam logic [THR_W-1:0]  THRESHOLD_RESET = THR_W'(40000);
  localparam logic [BYTE_W-1:0] FRAME_LEN_RESET = BYTE_W'(54);
  localparam logic [BITCNT_W-1:0] BITS_PER_BYTE = BITCNT_W'(8);

  localparam logic [CFG_IDX_W-1:0] REG_IDLE_THRESHOLD = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_LENGTH   = 1'b1;

  typedef struct packed {
    logic [THR_W-1:0]  idle_threshold;
    logic [BYTE_W-1:0] frame_length;
  } cfg_t;

  typedef struct packed {
    logic              last_of_frame;
    logic [BYTE_W-1:0] byte_index;
    logic [BYTE_W-1:0] byte_value;
  } res_t;

endpackage

// File: rtl/tws_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Configuration registers
// Holds the idle threshold and the frame length.
// ----------------------------------------------------------------------------
module tws_regs (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [tws_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [tws_pkg::CFG_W-1:0]     cfg_wdata,
  output tws_pkg::cfg_t                 cfg
);
  import tws_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        REG_IDLE_THRESHOLD: cfg_nxt.idle_threshold = cfg_wdata[THR_W-1:0];
        REG_FRAME_LENGTH:   cfg_nxt.frame_length   = cfg_wdata[BYTE_W-1:0];
        default:            cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.idle_threshold <= THRESHOLD_RESET;
      cfg_r.frame_length   <= FRAME_LEN_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// File: rtl/tws_capture.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Strobe run tracking and bit capture
// Detects frame starts and assembles bytes, one wire sample per request.
// ----------------------------------------------------------------------------
module tws_capture (
  input  logic          clk,
  input  logic          rst_n,
  input  tws_pkg::cfg_t cfg,
  input  logic          smp_en,
  input  logic          strobe_level,
  input  logic          clock_level,
  input  logic          data_level,
  output logic          res_valid,
  output tws_pkg::res_t res
);
  import tws_pkg::*;

  logic                strobe_prev_r, strobe_prev_nxt;
  logic                clock_prev_r, clock_prev_nxt;
  logic [RUN_W-1:0]    run_r, run_nxt;
  logic                capturing_r, capturing_nxt;
  logic [BYTE_W-1:0]   shift_r, shift_nxt;
  logic [BITCNT_W-1:0] bit_cnt_r, bit_cnt_nxt;
  logic [BYTE_W-1:0]   byte_cnt_r, byte_cnt_nxt;
  logic                frame_start;
  logic                last;

  always_comb begin
    strobe_prev_nxt = strobe_level;
    clock_prev_nxt  = clock_level;
    capturing_nxt   = capturing_r;
    shift_nxt       = shift_r;
    bit_cnt_nxt     = bit_cnt_r;
    byte_cnt_nxt    = byte_cnt_r;
    res_valid       = 1'b0;
    res             = '0;
    last            = 1'b0;
    frame_start     = !strobe_level && strobe_prev_r &&
                      (CMP_W'(run_r) > CMP_W'(cfg.idle_threshold));

    if (strobe_level) begin
      if (strobe_prev_r) begin
        run_nxt = (run_r == {RUN_W{1'b1}}) ? run_r : run_r + RUN_W'(1);
      end else begin
        run_nxt = '0;
      end
    end else begin
      run_nxt = '0;
    end

    if (frame_start) begin
      capturing_nxt = 1'b1;
      shift_nxt     = '0;
      bit_cnt_nxt   = '0;
      byte_cnt_nxt  = '0;
    end

    if (capturing_nxt && clock_level && !clock_prev_r) begin
      shift_nxt   = shift_nxt | (BYTE_W'(data_level) << bit_cnt_nxt[2:0]);
      bit_cnt_nxt = bit_cnt_nxt + BITCNT_W'(1);
      if (bit_cnt_nxt >= BITS_PER_BYTE) begin
        last = ({1'b0, byte_cnt_nxt} + 9'd1) >= {1'b0, cfg.frame_length};
        res_valid         = 1'b1;
        res.byte_value    = shift_nxt;
        res.byte_index    = byte_cnt_nxt;
        res.last_of_frame = last;
        byte_cnt_nxt      = byte_cnt_nxt + BYTE_W'(1);
        bit_cnt_nxt       = '0;
        shift_nxt         = '0;
        if (last) begin
          capturing_nxt = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strobe_prev_r <= 1'b0;
      clock_prev_r  <= 1'b0;
      run_r         <= '0;
      capturing_r   <= 1'b0;
      shift_r       <= '0;
      bit_cnt_r     <= '0;
      byte_cnt_r    <= '0;
    end else if (smp_en) begin
      strobe_prev_r <= strobe_prev_nxt;
      clock_prev_r  <= clock_prev_nxt;
      run_r         <= run_nxt;
      capturing_r   <= capturing_nxt;
      shift_r       <= shift_nxt;
      bit_cnt_r     <= bit_cnt_nxt;
      byte_cnt_r    <= byte_cnt_nxt;
    end
  end

  // Between requests a byte is never left complete in the shift register.
  a_bit_cnt_below_byte: assert property (@(posedge clk) disable iff (!rst_n)
    bit_cnt_r < BITS_PER_BYTE)
    else $error("bit count reached a full byte between samples");

  // Partial bits are only held while a frame is being captured.
  a_idle_clean: assert property (@(posedge clk) disable iff (!rst_n)
    !capturing_r |-> (bit_cnt_r == '0 && shift_r == '0))
    else $error("partial byte held outside a frame");

  // A result is only produced on a clock rising edge inside a frame.
  a_result_on_edge: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid |-> (capturing_nxt || res.last_of_frame) && clock_level && !clock_prev_r)
    else $error("byte emitted without a clock rising edge");

endmodule

// File: rtl/tws_out_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Result buffer
// Two-entry buffer that decouples result delivery from sample intake.
// ----------------------------------------------------------------------------
module tws_out_fifo (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  tws_pkg::res_t push_data,
  output logic          full,
  output logic          out_tvalid,
  input  logic          out_tready,
  output tws_pkg::res_t out_data
);
  import tws_pkg::*;

  res_t       mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;
  logic       pop;

  assign pop        = out_tvalid && out_tready;
  assign out_tvalid = (count_r != 2'd0);
  assign full       = (count_r == 2'd2);
  assign out_data   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? !rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full)
    else $error("result written into a full buffer");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= 2'd2)
    else $error("buffer count out of range");

  a_ptr_match: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == 2'd0 || count_r == 2'd2) |-> (wr_ptr_r == rd_ptr_r))
    else $error("buffer pointers disagree with count");

endmodule

// File: rtl/three_wire_bus_byte_sniffer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Three-wire bus byte sniffer
// Passive capture of LSB-first bytes from strobe, clock and data samples.
// ----------------------------------------------------------------------------
// Each request carries one sample of the three wires, and a new sample is
// accepted every clock while in_tready is high. A byte completed by a sample
// is registered into a two-entry buffer that feeds the result channel;
// in_tready falls only when both buffer entries are waiting. A frame
// starts on a strobe falling edge after a high run longer than idle_threshold
// and ends after frame_length bytes, the last one flagged with out_tlast.
// ----------------------------------------------------------------------------
module three_wire_bus_byte_sniffer (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [7:0]                    in_tdata,   // strobe_level, clock_level, data_level
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [15:0]                   out_tdata,  // byte_value, byte_index
  output logic                          out_tlast,
  input  logic                          cfg_we,
  input  logic [tws_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [tws_pkg::CFG_W-1:0]     cfg_wdata
);
  import tws_pkg::*;

  cfg_t cfg;
  res_t res;
  res_t out_res;
  logic res_valid;
  logic full;
  logic smp_en;

  assign in_tready = !full;
  assign smp_en    = in_tvalid && in_tready;

  tws_regs u_regs (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  tws_capture u_capture (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg          (cfg),
    .smp_en       (smp_en),
    .strobe_level (in_tdata[0]),
    .clock_level  (in_tdata[1]),
    .data_level   (in_tdata[2]),
    .res_valid    (res_valid),
    .res          (res)
  );

  tws_out_fifo u_out_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (smp_en && res_valid),
    .push_data  (res),
    .full       (full),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_data   (out_res)
  );

  assign out_tdata = {out_res.byte_index, out_res.byte_value};
  assign out_tlast = out_res.last_of_frame;

endmodule
